>>> rtl/slt_pkg.sv
`default_nettype none
package slt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 14;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_WINDOW_LEN = 24;
   localparam int DEF_MIN_FILL   = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP    = 2'd1;

   localparam logic [POS_W-1:0] RST_TIMEOUT = 14'd9000;
   localparam logic [POS_W-1:0] RST_WRAP    = 14'd10200;

   localparam logic signed [SAMPLE_W-1:0] DEF_MAX    = 16'sd3000;
   localparam logic signed [SAMPLE_W-1:0] DEF_MIN    = -16'sd3000;
   localparam logic signed [SAMPLE_W-1:0] DEF_CENTER = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] DEF_UMID   = 16'sd1000;
   localparam logic signed [SAMPLE_W-1:0] DEF_LMID   = -16'sd1000;

   // reciprocal of three for magnitudes below 2^18
   localparam int DIV3_SHIFT = 24;
   localparam logic [22:0] DIV3_K = 23'd5592406;

   typedef struct packed {
      logic accept;
      logic scan;
      logic div_mul;
      logic div_load;
      logic decide;
      logic lvl1;
      logic lvl2;
      logic lvl3;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full_next;
      logic full;
      logic found;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> rtl/slt_ctrl.sv
`default_nettype none
module slt_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire slt_pkg::sts_type sts,
   output slt_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DIVM   = 3'd2;
   localparam logic [2:0] ST_DIVL   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_LVL1   = 3'd5;
   localparam logic [2:0] ST_LVL23  = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       lvl3_ff, lvl3_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      lvl3_in  = lvl3_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = sts.full_next ? ST_SCAN : ST_DECIDE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = ST_DIVM;
         end
         ST_DIVM: begin
            cmd.div_mul = 1'b1;
            state_in = ST_DIVL;
         end
         ST_DIVL: begin
            cmd.div_load = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = sts.found ? ST_LVL1 : ST_EMIT;
         end
         ST_LVL1: begin
            cmd.lvl1 = 1'b1;
            lvl3_in  = 1'b0;
            state_in = ST_LVL23;
         end
         ST_LVL23: begin
            // center first, then the two mids
            if (lvl3_ff) begin
               cmd.lvl3 = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.lvl2 = 1'b1;
               lvl3_in  = 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl3_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl3_ff  <= lvl3_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/slt_dp.sv
`default_nettype none
module slt_dp #(
   parameter int WINDOW_LEN = slt_pkg::DEF_WINDOW_LEN,
   parameter int MIN_FILL   = slt_pkg::DEF_MIN_FILL
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire slt_pkg::cmd_type                       cmd,
   output slt_pkg::sts_type                            sts,
   input  wire logic signed [slt_pkg::SAMPLE_W-1:0]    in_sample,
   input  wire logic                                   in_hit,
   input  wire logic                                   csr_we,
   input  wire logic [slt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [slt_pkg::POS_W-1:0]              csr_wdata,
   input  wire logic                                   rsp_tready,
   output logic                                        rsp_tvalid,
   output logic                                        out_found,
   output logic                                        out_tout,
   output logic [slt_pkg::POS_W-1:0]                   out_offset,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_trim_lo,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_trim_hi,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_max,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_min,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_center,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_umid,
   output logic signed [slt_pkg::SAMPLE_W-1:0]         out_lmid
);

   localparam int SW    = slt_pkg::SAMPLE_W;
   localparam int PW    = slt_pkg::POS_W;
   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(MIN_FILL + 1);
   localparam int SUM_W = SW + 2;
   localparam int PROD_W = SUM_W + 23;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
   localparam logic [IDX_W-1:0] HI_LO   = IDX_W'(WINDOW_LEN - 5);
   localparam logic [IDX_W-1:0] HI_HI   = IDX_W'(WINDOW_LEN - 3);
   localparam logic [IDX_W-1:0] LO_LO   = IDX_W'(2);
   localparam logic [IDX_W-1:0] LO_HI   = IDX_W'(4);

   function automatic logic signed [SW-1:0] half(input logic signed [SW:0] x);
      logic signed [SW:0] t;
      t = x + {{SW{1'b0}}, x[SW]};
      return SW'(t >>> 1);
   endfunction

   // center + (level - center) * 5 / 8, truncating toward zero
   function automatic logic signed [SW-1:0] mid(input logic signed [SW-1:0] lvl,
                                                input logic signed [SW-1:0] ctr);
      logic signed [SW:0]   d;
      logic signed [SW+3:0] p;
      logic signed [SW+3:0] m;
      d = {lvl[SW-1], lvl} - {ctr[SW-1], ctr};
      p = {{3{d[SW]}}, d} + ({{3{d[SW]}}, d} <<< 2);
      m = (p + (p[SW+3] ? (SW+4)'(7) : (SW+4)'(0))) >>> 3;
      return SW'(m + {{4{ctr[SW-1]}}, ctr});
   endfunction

   logic [PW-1:0] timeout_ff, wrap_ff;

   logic signed [SW-1:0] win_ff [WINDOW_LEN];
   logic [IDX_W-1:0]     slot_ff;
   logic [CNT_W-1:0]     seen_ff;
   logic [PW-1:0]        pos_ff;
   logic                 sync_ff;
   logic                 hit_ff;
   logic signed [SW-1:0] trim_lo_ff, trim_hi_ff;
   logic signed [SW-1:0] max_ff, min_ff, ctr_ff, umid_ff, lmid_ff;

   logic [IDX_W-1:0]      idx_ff;
   logic signed [SUM_W-1:0] sum_lo_ff, sum_hi_ff;
   logic [PROD_W-1:0]     prod_lo_ff, prod_hi_ff;
   logic                  neg_lo_ff, neg_hi_ff;

   logic                 res_found_ff, res_tout_ff;
   logic [PW-1:0]        res_offset_ff;
   logic signed [SW-1:0] res_lo_ff, res_hi_ff;

   logic signed [SW-1:0] cur;
   logic [IDX_W-1:0]     rank;
   logic [SUM_W-1:0]     mag_lo, mag_hi;
   logic signed [SW-1:0] q_lo, q_hi;
   logic [PW-1:0]        pos_step;
   logic                 sync_step;
   logic                 restart;

   assign sts.full_next = (seen_ff >= CNT_W'(MIN_FILL - 1));
   assign sts.full      = (seen_ff >= CNT_W'(MIN_FILL));
   assign sts.found     = sts.full && hit_ff;
   assign sts.scan_last = (idx_ff == LAST_IDX);
   assign sts.out_free  = !rsp_tvalid || rsp_tready;

   // stable rank of the entry under scan
   always_comb begin
      int cnt;
      cur = win_ff[idx_ff];
      cnt = 0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if (win_ff[j] < cur || (win_ff[j] == cur && IDX_W'(j) < idx_ff)) cnt = cnt + 1;
      end
      rank = IDX_W'(cnt);
   end

   assign mag_lo = sum_lo_ff[SUM_W-1] ? SUM_W'(-sum_lo_ff) : SUM_W'(sum_lo_ff);
   assign mag_hi = sum_hi_ff[SUM_W-1] ? SUM_W'(-sum_hi_ff) : SUM_W'(sum_hi_ff);

   always_comb begin
      logic [SW-1:0] a, b;
      a = SW'(prod_lo_ff >> slt_pkg::DIV3_SHIFT);
      b = SW'(prod_hi_ff >> slt_pkg::DIV3_SHIFT);
      q_lo = neg_lo_ff ? -$signed(a) : $signed(a);
      q_hi = neg_hi_ff ? -$signed(b) : $signed(b);
   end

   always_comb begin
      if (pos_ff < wrap_ff) begin
         pos_step  = pos_ff + PW'(1);
         sync_step = sync_ff;
      end else begin
         pos_step  = '0;
         sync_step = 1'b0;
      end
   end

   assign restart = cmd.decide && (sts.found || (sync_step && pos_step >= timeout_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= slt_pkg::RST_TIMEOUT;
         wrap_ff    <= slt_pkg::RST_WRAP;
      end else if (csr_we) begin
         unique case (csr_index)
            slt_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            slt_pkg::CSR_WRAP:    wrap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
         slot_ff    <= '0;
         seen_ff    <= '0;
         pos_ff     <= '0;
         sync_ff    <= 1'b0;
         trim_lo_ff <= '0;
         trim_hi_ff <= '0;
         max_ff     <= slt_pkg::DEF_MAX;
         min_ff     <= slt_pkg::DEF_MIN;
         ctr_ff     <= slt_pkg::DEF_CENTER;
         umid_ff    <= slt_pkg::DEF_UMID;
         lmid_ff    <= slt_pkg::DEF_LMID;
         rsp_tvalid <= 1'b0;
      end else begin
         if (cmd.accept) begin
            win_ff[slot_ff] <= in_sample;
            slot_ff <= (slot_ff == LAST_IDX) ? '0 : slot_ff + IDX_W'(1);
            if (!sts.full) seen_ff <= seen_ff + CNT_W'(1);
         end
         if (cmd.div_load) begin
            trim_lo_ff <= q_lo;
            trim_hi_ff <= q_hi;
         end
         if (cmd.decide) begin
            if (sts.found) begin
               sync_ff <= 1'b1;
            end else if (restart) begin
               sync_ff <= 1'b0;
               max_ff  <= slt_pkg::DEF_MAX;
               min_ff  <= slt_pkg::DEF_MIN;
               ctr_ff  <= slt_pkg::DEF_CENTER;
               umid_ff <= slt_pkg::DEF_UMID;
               lmid_ff <= slt_pkg::DEF_LMID;
            end else begin
               sync_ff <= sync_step;
               pos_ff  <= pos_step;
            end
            if (restart) begin
               for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
               slot_ff    <= '0;
               seen_ff    <= '0;
               pos_ff     <= '0;
               trim_lo_ff <= '0;
               trim_hi_ff <= '0;
            end
         end
         if (cmd.lvl1) begin
            max_ff <= half({max_ff[SW-1], max_ff} + {res_hi_ff[SW-1], res_hi_ff});
            min_ff <= half({min_ff[SW-1], min_ff} + {res_lo_ff[SW-1], res_lo_ff});
         end
         if (cmd.lvl2) ctr_ff <= half({max_ff[SW-1], max_ff} + {min_ff[SW-1], min_ff});
         if (cmd.lvl3) begin
            umid_ff <= mid(max_ff, ctr_ff);
            lmid_ff <= mid(min_ff, ctr_ff);
         end
         if (cmd.emit) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hit_ff    <= in_hit;
         idx_ff    <= '0;
         sum_lo_ff <= '0;
         sum_hi_ff <= '0;
      end
      if (cmd.scan) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (rank >= LO_LO && rank <= LO_HI) sum_lo_ff <= sum_lo_ff + SUM_W'(cur);
         if (rank >= HI_LO && rank <= HI_HI) sum_hi_ff <= sum_hi_ff + SUM_W'(cur);
      end
      if (cmd.div_mul) begin
         prod_lo_ff <= PROD_W'(mag_lo) * PROD_W'(slt_pkg::DIV3_K);
         prod_hi_ff <= PROD_W'(mag_hi) * PROD_W'(slt_pkg::DIV3_K);
         neg_lo_ff  <= sum_lo_ff[SUM_W-1];
         neg_hi_ff  <= sum_hi_ff[SUM_W-1];
      end
      if (cmd.decide) begin
         res_found_ff  <= sts.found;
         res_tout_ff   <= restart && !sts.found;
         res_offset_ff <= sts.found ? pos_ff : '0;
         res_lo_ff     <= trim_lo_ff;
         res_hi_ff     <= trim_hi_ff;
      end
      if (cmd.emit) begin
         out_found   <= res_found_ff;
         out_tout    <= res_tout_ff;
         out_offset  <= res_offset_ff;
         out_trim_lo <= res_lo_ff;
         out_trim_hi <= res_hi_ff;
         out_max     <= max_ff;
         out_min     <= min_ff;
         out_center  <= ctr_ff;
         out_umid    <= umid_ff;
         out_lmid    <= lmid_ff;
      end
   end

endmodule
`default_nettype wire

>>> rtl/symbol_level_tracker.sv
`default_nettype none
// channel  dir  tdata                                   tuser
// req      in   [15:0] sample                           [0] sync_hit
// rsp      out  [13:0] sync_offset [29:14] trim_low     [0] sync_found
//               [45:30] trim_high [61:46] level_max     [1] timed_out
//               [77:62] level_min [93:78] level_center
//               [109:94] upper_mid [125:110] lower_mid
// csr      in   csr_we, csr_index (0 timeout, 1 wrap), csr_wdata
//
// before the window has MIN_FILL samples an item skips the scan and divide
// later items scan and divide, levels update on a sync: the rank scan visits
// one window entry a cycle against all others, then a multiply-based divide
// one item in flight; req_tready is high only while idle
// a waiting result holds in the output register while the next item is taken
// synchronous reset restores defaults and clears the window
module symbol_level_tracker #(
   parameter int WINDOW_LEN = slt_pkg::DEF_WINDOW_LEN,
   parameter int MIN_FILL   = slt_pkg::DEF_MIN_FILL
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [15:0]                       req_tdata,  // sample
   input  wire logic                              req_tuser,  // sync_hit
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [127:0]                           rsp_tdata,  // see table above
   output logic [1:0]                             rsp_tuser,  // sync_found, timed_out
   input  wire logic                              csr_we,
   input  wire logic [slt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [slt_pkg::POS_W-1:0]         csr_wdata
);

   slt_pkg::cmd_type cmd;
   slt_pkg::sts_type sts;

   logic                 o_found, o_tout;
   logic [13:0]          o_offset;
   logic signed [15:0]   o_lo, o_hi, o_max, o_min, o_ctr, o_umid, o_lmid;

   slt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   slt_dp #(
      .WINDOW_LEN (WINDOW_LEN),
      .MIN_FILL   (MIN_FILL)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_sample   ($signed(req_tdata)),
      .in_hit      (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .out_found   (o_found),
      .out_tout    (o_tout),
      .out_offset  (o_offset),
      .out_trim_lo (o_lo),
      .out_trim_hi (o_hi),
      .out_max     (o_max),
      .out_min     (o_min),
      .out_center  (o_ctr),
      .out_umid    (o_umid),
      .out_lmid    (o_lmid)
   );

   assign rsp_tdata = {2'b00, o_lmid, o_umid, o_ctr, o_min, o_max, o_hi, o_lo, o_offset};
   assign rsp_tuser = {o_tout, o_found};

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("sync found and timeout in one result");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in flight");

   a_timeout_defaults: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (rsp_tdata[61:46] == 16'd3000 && rsp_tdata[93:78] == 16'd0))
      else $error("timeout result without default levels");

   a_offset_only_on_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[13:0] == 14'd0))
      else $error("offset reported without sync");

endmodule
`default_nettype wire
